// ----- rtl/dhst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhst_pkg
// Shared types and constants of the daily heating schedule table.
// ----------------------------------------------------------------------------
package dhst_pkg;

    // field widths
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned SLOT_W   = 3;
    localparam int unsigned MIN_W    = 11;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned CFG_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned STORE_W  = 8;

    // time constants
    localparam logic [MIN_W:0]     MINUTES_IN_DAY = 12'd1440;
    localparam logic [STORE_W-1:0] ERASED_SLOT    = 8'd255;

    // register reset values
    localparam logic [CFG_W-1:0] PREWARM_RST   = 8'd36;
    localparam logic [CFG_W-1:0] LOOKAHEAD_RST = 8'd54;
    localparam logic [CFG_W-1:0] ON_PERIOD_RST = 8'd60;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PREWARM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_PERIOD = 2'd2;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_SET   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SLOT = 2'd1,
        ST_BAD_TIME = 2'd2
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic              load;    // capture request fields
        logic              exec;    // check, write table, set up scan
        logic              mul;     // fetch slot and scale to minutes
        logic              eval;    // on/off times and warm tests
        logic              finish;  // sample any-set flag
        logic [SLOT_W-1:0] idx;     // slot under scan
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_query;
    } t_dp_stat;

endpackage

// ----- rtl/daily_heating_schedule_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daily_heating_schedule_table
// Table of daily heating start slots with set, clear and query requests.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  request   | start, busy            | i_req_type, i_slot, i_minutes
//  result    | o_done (1-cycle strobe)| o_status, o_any_set, o_slot_valid,
//            |                        | o_slot_on_mins, o_slot_off_mins,
//            |                        | o_warm_now, o_warm_soon
//  config    | i_cfg_we               | i_cfg_idx, i_cfg_data
//
//  Set, clear and no-op: the sequencer passes S_EXEC and S_DONE after the
//  request transfer, before the registered result strobe. Query: a slot scan
//  runs in between: fetch/scale, then evaluation, per slot in the shared datapath.
//  A new request can be taken in the cycle the result strobe is high.
//  Reset (synchronous, active low) erases all slots and loads register
//  defaults; there is no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module daily_heating_schedule_table #(
    parameter int unsigned SLOT_COUNT       = 2,
    parameter int unsigned GRANULARITY_MINS = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [dhst_pkg::REQ_W-1:0]      i_req_type,
    input  logic [dhst_pkg::SLOT_W-1:0]     i_slot,
    input  logic [dhst_pkg::MIN_W-1:0]      i_minutes,
    input  logic                            i_cfg_we,
    input  logic [dhst_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dhst_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                            o_done,
    output logic [dhst_pkg::STAT_W-1:0]     o_status,
    output logic                            o_any_set,
    output logic                            o_slot_valid,
    output logic [dhst_pkg::MIN_W-1:0]      o_slot_on_mins,
    output logic [dhst_pkg::MIN_W-1:0]      o_slot_off_mins,
    output logic                            o_warm_now,
    output logic                            o_warm_soon
);
    import dhst_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    dhst_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // table and arithmetic
    dhst_dp #(
        .SLOT_COUNT       (SLOT_COUNT),
        .GRANULARITY_MINS (GRANULARITY_MINS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_slot          (i_slot),
        .i_minutes       (i_minutes),
        .o_status        (o_status),
        .o_any_set       (o_any_set),
        .o_slot_valid    (o_slot_valid),
        .o_slot_on_mins  (o_slot_on_mins),
        .o_slot_off_mins (o_slot_off_mins),
        .o_warm_now      (o_warm_now),
        .o_warm_soon     (o_warm_soon)
    );

endmodule

// ----- rtl/dhst_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhst_ctrl
// Request sequencer: accepts a request, runs the slot scan for queries and
// raises the one-cycle result strobe.
// ----------------------------------------------------------------------------
module dhst_ctrl #(
    parameter int unsigned SLOT_COUNT = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    output logic               o_done,
    input  dhst_pkg::t_dp_stat i_stat,
    output dhst_pkg::t_dp_cmd  o_cmd
);
    import dhst_pkg::*;

    localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_EVAL,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx;
    logic             r_done;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_EXEC;
            S_EXEC: n_state = i_stat.is_query ? S_MUL : S_DONE;
            S_MUL:  n_state = S_EVAL;
            S_EVAL: n_state = (r_idx == LAST_IDX) ? S_DONE : S_MUL;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state, scan index and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_DONE);
            if (r_state == S_EXEC) begin
                r_idx <= '0;
            end else if (r_state == S_EVAL && r_idx != LAST_IDX) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // commands
    always_comb begin
        o_cmd.load   = i_start && (r_state == S_IDLE);
        o_cmd.exec   = (r_state == S_EXEC);
        o_cmd.mul    = (r_state == S_MUL);
        o_cmd.eval   = (r_state == S_EVAL);
        o_cmd.finish = (r_state == S_DONE);
        o_cmd.idx    = SLOT_W'(r_idx);
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    // checks
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == S_IDLE) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter exec");

    a_eval_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ($past(r_state) == S_MUL))
        else $error("eval without preceding fetch");

    a_scan_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && $past(r_state) == S_EXEC) |-> i_stat.is_query)
        else $error("slot scan started for a non-query request");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && $past(r_state) != S_IDLE) |-> ($past(r_state) == S_DONE))
        else $error("request ended without result");

endmodule

// ----- rtl/dhst_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhst_dp
// Datapath: slot table, configuration registers, start-time divider and the
// per-slot on/off and warm evaluation.
// ----------------------------------------------------------------------------
module dhst_dp #(
    parameter int unsigned SLOT_COUNT       = 2,
    parameter int unsigned GRANULARITY_MINS = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dhst_pkg::t_dp_cmd               i_cmd,
    output dhst_pkg::t_dp_stat              o_stat,
    input  logic                            i_cfg_we,
    input  logic [dhst_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dhst_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [dhst_pkg::REQ_W-1:0]      i_req_type,
    input  logic [dhst_pkg::SLOT_W-1:0]     i_slot,
    input  logic [dhst_pkg::MIN_W-1:0]      i_minutes,
    output logic [dhst_pkg::STAT_W-1:0]     o_status,
    output logic                            o_any_set,
    output logic                            o_slot_valid,
    output logic [dhst_pkg::MIN_W-1:0]      o_slot_on_mins,
    output logic [dhst_pkg::MIN_W-1:0]      o_slot_off_mins,
    output logic                            o_warm_now,
    output logic                            o_warm_soon
);
    import dhst_pkg::*;

    localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [STORE_W-1:0] MAX_STORED = STORE_W'(1440 / GRANULARITY_MINS - 1);
    // scaled slot value, wide enough for an erased entry
    localparam int unsigned T_W = $clog2(255 * GRANULARITY_MINS + 1);
    // minutes / granularity as a reciprocal multiply, exact for minutes < 2048
    localparam int unsigned DIV_SH    = 17;
    localparam int unsigned DIV_RECIP = (2 ** DIV_SH + GRANULARITY_MINS - 1) / GRANULARITY_MINS;
    localparam int unsigned DIV_RW    = $clog2(DIV_RECIP + 1);
    localparam int unsigned PROD_W    = (MIN_W + DIV_RW > DIV_SH + STORE_W) ?
                                        (MIN_W + DIV_RW) : (DIV_SH + STORE_W);

    // request registers
    t_req               r_req;
    logic [SLOT_W-1:0]  r_slot;
    logic [MIN_W-1:0]   r_mins;

    // configuration
    logic [CFG_W-1:0]   r_prewarm, r_lookahead, r_on_period;

    // table and scan registers
    logic [STORE_W-1:0] r_slots [SLOT_COUNT];
    logic [STORE_W-1:0] r_cur;
    logic [T_W-1:0]     r_t;
    logic [MIN_W-1:0]   r_ahead;

    // result registers
    t_status            r_status;
    logic               r_any_set;
    logic               r_valid;
    logic [MIN_W-1:0]   r_on, r_off;
    logic               r_now, r_soon;

    // request checks
    logic               slot_good, time_good;
    t_status            n_status;
    logic               wr_en;
    logic [STORE_W-1:0] wr_val;
    logic [PROD_W-1:0]  div_prod;
    logic [MIN_W:0]     ahead_sum;

    assign slot_good = ({1'b0, r_slot} < (SLOT_W + 1)'(SLOT_COUNT));
    assign time_good = ({1'b0, r_mins} < MINUTES_IN_DAY);
    assign div_prod  = PROD_W'(r_mins) * PROD_W'(DIV_RECIP);
    assign ahead_sum = {1'b0, r_mins} + (MIN_W + 1)'(r_lookahead);

    always_comb begin
        n_status = ST_OK;
        wr_en    = 1'b0;
        wr_val   = ERASED_SLOT;
        case (r_req)
            REQ_SET: begin
                if (!slot_good) n_status = ST_BAD_SLOT;
                else if (!time_good) n_status = ST_BAD_TIME;
                wr_en  = slot_good && time_good;
                wr_val = div_prod[DIV_SH +: STORE_W];
            end
            REQ_CLEAR: begin
                if (!slot_good) n_status = ST_BAD_SLOT;
                wr_en = slot_good;
            end
            REQ_QUERY: begin
                if (!slot_good) n_status = ST_BAD_SLOT;
                else if (!time_good) n_status = ST_BAD_TIME;
            end
            default: n_status = ST_OK;
        endcase
    end

    // per-slot evaluation from the scaled start
    logic [MIN_W-1:0] t11;
    logic             cur_set, wrap;
    logic [MIN_W:0]   on_t, sum_t, off_t, end_t;
    logic             hit_now, hit_soon, named;

    assign t11     = MIN_W'(r_t);
    assign cur_set = (r_cur <= MAX_STORED);
    assign wrap    = ({3'b0, r_prewarm} > t11);

    always_comb begin
        on_t  = wrap ? ({1'b0, t11} + MINUTES_IN_DAY - (MIN_W + 1)'(r_prewarm))
                     : ({1'b0, t11} - (MIN_W + 1)'(r_prewarm));
        sum_t = {1'b0, t11} + (MIN_W + 1)'(r_on_period);
        if (wrap) off_t = sum_t;
        else if (sum_t >= MINUTES_IN_DAY) off_t = sum_t - MINUTES_IN_DAY;
        else off_t = sum_t;
        end_t = (off_t < on_t) ? (off_t + MINUTES_IN_DAY) : off_t;
        hit_now  = cur_set && ({1'b0, r_mins} >= on_t) && ({1'b0, r_mins} < end_t);
        hit_soon = cur_set && ({1'b0, r_ahead} >= on_t) && ({1'b0, r_ahead} < end_t);
        named    = (r_slot == i_cmd.idx);
    end

    // any slot set, over all entries
    logic any_set;
    always_comb begin
        any_set = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            any_set = any_set | (r_slots[i] <= MAX_STORED);
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prewarm   <= PREWARM_RST;
            r_lookahead <= LOOKAHEAD_RST;
            r_on_period <= ON_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PREWARM:   r_prewarm   <= i_cfg_data;
                CFG_LOOKAHEAD: r_lookahead <= i_cfg_data;
                CFG_ON_PERIOD: r_on_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // slot table
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!i_rst_n) begin
                r_slots[i] <= ERASED_SLOT;
            end else if (i_cmd.exec && wr_en && r_slot == SLOT_W'(i)) begin
                r_slots[i] <= wr_val;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= t_req'(i_req_type);
            r_slot <= i_slot;
            r_mins <= i_minutes;
        end
    end

    // fetch and scale
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_cur <= r_slots[i_cmd.idx[IDX_W-1:0]];
            r_t   <= T_W'(r_slots[i_cmd.idx[IDX_W-1:0]]) * T_W'(GRANULARITY_MINS);
        end
    end

    // results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= ST_OK;
            r_any_set <= 1'b0;
            r_valid   <= 1'b0;
            r_on      <= '0;
            r_off     <= '0;
            r_now     <= 1'b0;
            r_soon    <= 1'b0;
            r_ahead   <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_status <= n_status;
                r_valid  <= 1'b0;
                r_on     <= '0;
                r_off    <= '0;
                r_now    <= 1'b0;
                r_soon   <= 1'b0;
                r_ahead  <= (ahead_sum >= MINUTES_IN_DAY) ? MIN_W'(ahead_sum - MINUTES_IN_DAY)
                                                           : MIN_W'(ahead_sum);
            end
            if (i_cmd.eval) begin
                r_now  <= r_now | hit_now;
                r_soon <= r_soon | hit_soon;
                if (named) begin
                    r_valid <= cur_set;
                    r_on    <= cur_set ? MIN_W'(on_t) : '0;
                    r_off   <= cur_set ? MIN_W'(off_t) : '0;
                end
            end
            if (i_cmd.finish) begin
                r_any_set <= any_set;
            end
        end
    end

    assign o_stat.is_query = (r_req == REQ_QUERY);

    assign o_status        = r_status;
    assign o_any_set       = r_any_set;
    assign o_slot_valid    = r_valid;
    assign o_slot_on_mins  = r_on;
    assign o_slot_off_mins = r_off;
    assign o_warm_now      = r_now;
    assign o_warm_soon     = r_soon;

    // checks
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.exec) |-> (r_status == ST_OK || r_status == ST_BAD_SLOT ||
                               r_status == ST_BAD_TIME))
        else $error("undefined status code");

    a_times_in_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.eval) |-> ({1'b0, r_on} < MINUTES_IN_DAY &&
                               {1'b0, r_off} < MINUTES_IN_DAY))
        else $error("slot on/off time outside one day");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> (r_on == '0 && r_off == '0))
        else $error("times reported for an unset slot");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the daily heating schedule table. Set, clear, query
// and no-op requests go in through the start/busy port, first a directed
// list, then random traffic under several register settings. A scoreboard
// keeps its own copy of the slot table and registers, predicts each report
// and compares it field by field with what comes out on the done strobe.
// ----------------------------------------------------------------------------
module tb;
    import dhst_pkg::*;

    localparam int unsigned SLOTS       = 2;
    localparam int unsigned GRAN        = 6;
    localparam int unsigned DAY_MINS    = MINUTES_IN_DAY;
    localparam int unsigned MAX_CODE    = DAY_MINS / GRAN - 1;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS = 310;
    localparam int unsigned MAX_PRINTS  = 50;
    // index with no register behind it, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // one report as seen on the result ports
    typedef struct packed {
        t_status          status;
        logic             any_set;
        logic             slot_valid;
        logic [MIN_W-1:0] on_mins;
        logic [MIN_W-1:0] off_mins;
        logic             warm_now;
        logic             warm_soon;
    } t_report;

    // ------------------------------------------------------------------------
    // Scoreboard: schedule table mirror, report prediction and checking
    // ------------------------------------------------------------------------
    class heating_scoreboard;
        logic [STORE_W-1:0] start_codes [SLOTS];
        int unsigned        prewarm;
        int unsigned        lookahead;
        int unsigned        on_period;
        t_report            pending_reports [$];
        int unsigned        errors;

        function void reset_state();
            foreach (start_codes[i]) start_codes[i] = ERASED_SLOT;
            prewarm   = PREWARM_RST;
            lookahead = LOOKAHEAD_RST;
            on_period = ON_PERIOD_RST;
            errors    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_PREWARM:   prewarm   = data;
                CFG_LOOKAHEAD: lookahead = data;
                CFG_ON_PERIOD: on_period = data;
                default: ;
            endcase
        endfunction

        function bit slot_set(int unsigned i);
            return i < SLOTS && start_codes[i] <= MAX_CODE;
        endfunction

        // start wound back by the pre-warm, wrapped at midnight
        function int unsigned on_minute(int unsigned i);
            int unsigned t;
            t = GRAN * start_codes[i];
            if (prewarm > t) t += DAY_MINS;
            return t - prewarm;
        endfunction

        function int unsigned off_minute(int unsigned i);
            int unsigned t;
            t = on_minute(i) + prewarm + on_period;
            if (t >= DAY_MINS) t -= DAY_MINS;
            return t;
        endfunction

        function bit some_slot_set();
            for (int unsigned i = 0; i < SLOTS; i++)
                if (slot_set(i)) return 1'b1;
            return 1'b0;
        endfunction

        // no check across midnight below the on time: wrapped periods miss
        // their early-morning part
        function bit warm_at(int unsigned m);
            int unsigned s;
            int unsigned e;
            for (int unsigned i = 0; i < SLOTS; i++) begin
                if (!slot_set(i)) continue;
                s = on_minute(i);
                if (m < s) continue;
                e = off_minute(i);
                if (e < s) e += DAY_MINS;
                if (m < e) return 1'b1;
            end
            return 1'b0;
        endfunction

        // called on every request transfer
        function void note_request(t_req req, logic [SLOT_W-1:0] slot,
                                   logic [MIN_W-1:0] mins);
            t_report     rep;
            int unsigned ahead;
            rep = '0;
            rep.status = ST_OK;
            case (req)
                REQ_SET: begin
                    if (slot >= SLOTS)
                        rep.status = ST_BAD_SLOT;
                    else if (mins >= DAY_MINS)
                        rep.status = ST_BAD_TIME;
                    else
                        start_codes[slot] = STORE_W'(mins / GRAN);
                end
                REQ_CLEAR: begin
                    if (slot >= SLOTS)
                        rep.status = ST_BAD_SLOT;
                    else
                        start_codes[slot] = ERASED_SLOT;
                end
                REQ_QUERY: begin
                    if (slot >= SLOTS)
                        rep.status = ST_BAD_SLOT;
                    else if (mins >= DAY_MINS)
                        rep.status = ST_BAD_TIME;
                    if (slot_set(slot)) begin
                        rep.slot_valid = 1'b1;
                        rep.on_mins    = MIN_W'(on_minute(slot));
                        rep.off_mins   = MIN_W'(off_minute(slot));
                    end
                    rep.warm_now = warm_at(mins);
                    ahead = mins + lookahead;
                    if (ahead >= DAY_MINS) ahead -= DAY_MINS;
                    rep.warm_soon = warm_at(ahead);
                end
                default: ;
            endcase
            rep.any_set = some_slot_set();
            pending_reports.push_back(rep);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                if (errors <= MAX_PRINTS)
                    $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        // called on every result strobe
        function void check_report(t_report got);
            t_report want;
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= MAX_PRINTS)
                    $display("%0t: result with no request outstanding", $time);
                return;
            end
            want = pending_reports.pop_front();
            compare("status",        want.status,     got.status);
            compare("any_set",       want.any_set,    got.any_set);
            compare("slot_valid",    want.slot_valid, got.slot_valid);
            compare("slot_on_mins",  want.on_mins,    got.on_mins);
            compare("slot_off_mins", want.off_mins,   got.off_mins);
            compare("warm_now",      want.warm_now,   got.warm_now);
            compare("warm_soon",     want.warm_soon,  got.warm_soon);
        endfunction

        function int unsigned pending();
            return pending_reports.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic [REQ_W-1:0]     i_req_type = '0;
    logic [SLOT_W-1:0]    i_slot     = '0;
    logic [MIN_W-1:0]     i_minutes  = '0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 busy;
    logic                 o_done;
    logic [STAT_W-1:0]    o_status;
    logic                 o_any_set;
    logic                 o_slot_valid;
    logic [MIN_W-1:0]     o_slot_on_mins;
    logic [MIN_W-1:0]     o_slot_off_mins;
    logic                 o_warm_now;
    logic                 o_warm_soon;

    heating_scoreboard sb = new;
    t_report           seen;
    bit                steady = 1'b0;
    int unsigned       quiet_cycles = 0;

    daily_heating_schedule_table #(
        .SLOT_COUNT       (SLOTS),
        .GRANULARITY_MINS (GRAN)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_slot          (i_slot),
        .i_minutes       (i_minutes),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_any_set       (o_any_set),
        .o_slot_valid    (o_slot_valid),
        .o_slot_on_mins  (o_slot_on_mins),
        .o_slot_off_mins (o_slot_off_mins),
        .o_warm_now      (o_warm_now),
        .o_warm_soon     (o_warm_soon)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // check the result before noting a request taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                seen.status     = t_status'(o_status);
                seen.any_set    = o_any_set;
                seen.slot_valid = o_slot_valid;
                seen.on_mins    = o_slot_on_mins;
                seen.off_mins   = o_slot_off_mins;
                seen.warm_now   = o_warm_now;
                seen.warm_soon  = o_warm_soon;
                sb.check_report(seen);
            end
            if (start && !busy)
                sb.note_request(t_req'(i_req_type), i_slot, i_minutes);
        end
    end

    // watchdog: too long without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("daily_heating_schedule_table: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // mostly short gaps, a few long ones, none during a steady stretch
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // start low, noise on the request fields
    task automatic idle_cycles(input int unsigned n);
        start <= 1'b0;
        repeat (n) begin
            i_req_type <= REQ_W'($urandom);
            i_slot     <= SLOT_W'($urandom);
            i_minutes  <= MIN_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    // one request transfer; start stays high when no gap follows
    task automatic issue(input t_req req, input logic [SLOT_W-1:0] slot,
                         input logic [MIN_W-1:0] mins, input int unsigned gap);
        start      <= 1'b1;
        i_req_type <= req;
        i_slot     <= slot;
        i_minutes  <= mins;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (gap > 0) idle_cycles(gap);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_register(idx, data);
    endtask

    // registers change only with nothing in flight
    task automatic program_registers(input logic [CFG_W-1:0] pw,
                                     input logic [CFG_W-1:0] la,
                                     input logic [CFG_W-1:0] op);
        idle_cycles(1);
        while (sb.pending() != 0) @(posedge i_clk);
        write_register(CFG_PREWARM, pw);
        write_register(CFG_LOOKAHEAD, la);
        write_register(CFG_ON_PERIOD, op);
        write_register(CFG_UNUSED, CFG_W'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_directed();
        // empty table, then bad slot ahead of bad time
        issue(REQ_QUERY, 3'd0, 11'd0,    gap_len());
        issue(REQ_SET,   3'd7, 11'd2047, gap_len());
        issue(REQ_SET,   3'd0, 11'd1440, gap_len());
        issue(REQ_SET,   3'd0, 11'd2047, gap_len());
        // start at midnight: pre-warm wraps into the previous day
        issue(REQ_SET,   3'd0, 11'd0,    gap_len());
        issue(REQ_QUERY, 3'd0, 11'd1404, gap_len());
        issue(REQ_QUERY, 3'd0, 11'd30,   gap_len());
        issue(REQ_SET,   3'd1, 11'd1439, gap_len());
        issue(REQ_QUERY, 3'd1, 11'd1439, gap_len());
        issue(REQ_QUERY, 3'd2, 11'd100,  gap_len());
        // bad time: warm flags from the raw minute, look-ahead wraps once
        issue(REQ_QUERY, 3'd1, 11'd2047, gap_len());
        issue(REQ_QUERY, 3'd7, 11'd1440, gap_len());
        issue(REQ_CLEAR, 3'd5, 11'd0,    gap_len());
        issue(REQ_CLEAR, 3'd0, 11'd0,    gap_len());
        issue(REQ_QUERY, 3'd0, 11'd1398, gap_len());
        issue(REQ_NOP,   3'd7, 11'd2047, gap_len());
        // start rounds down to the granularity
        issue(REQ_SET,   3'd1, 11'd5,    gap_len());
        issue(REQ_QUERY, 3'd1, 11'd1420, gap_len());
        issue(REQ_CLEAR, 3'd1, 11'd0,    gap_len());
        issue(REQ_QUERY, 3'd1, 11'd0,    gap_len());
        // midday slot, edges of its warm window
        issue(REQ_SET,   3'd0, 11'd720,  gap_len());
        issue(REQ_QUERY, 3'd0, 11'd684,  gap_len());
        issue(REQ_QUERY, 3'd0, 11'd779,  gap_len());
        issue(REQ_QUERY, 3'd0, 11'd780,  gap_len());
    endtask

    task automatic run_random(input int unsigned count);
        t_req              req;
        logic [SLOT_W-1:0] slot;
        logic [MIN_W-1:0]  mins;
        int unsigned       pick;
        int unsigned       base;
        int unsigned       k;
        for (k = 0; k < count; k++) begin
            if (k % 64 == 0) steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            slot = ($urandom_range(0, 99) < 85) ? SLOT_W'($urandom_range(0, SLOTS - 1))
                                                : SLOT_W'($urandom_range(0, 7));
            mins = MIN_W'($urandom_range(0, DAY_MINS - 1));
            if (pick < 28) begin
                req = REQ_SET;
                case ($urandom_range(0, 9))
                    0:       mins = MIN_W'($urandom_range(0, 300));
                    1:       mins = MIN_W'($urandom_range(DAY_MINS, 2047));
                    default: ;
                endcase
            end else if (pick < 40) begin
                req = REQ_CLEAR;
            end else if (pick < 95) begin
                req  = REQ_QUERY;
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    // land near a stored start so warm windows are hit
                    base = sb.start_codes[$urandom_range(0, SLOTS - 1)];
                    base = (base <= MAX_CODE) ? base * GRAN
                                              : $urandom_range(0, DAY_MINS - 1);
                    mins = MIN_W'((base + DAY_MINS + $urandom_range(0, 420) - 300)
                                  % DAY_MINS);
                end else if (pick < 55) begin
                    mins = MIN_W'($urandom_range(0, 2047));
                end
            end else begin
                req  = REQ_NOP;
                slot = SLOT_W'($urandom);
                mins = MIN_W'($urandom);
            end
            issue(req, slot, mins, gap_len());
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        sb.reset_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(PHASE_ITEMS);
        program_registers(8'd0, 8'd0, 8'd0);
        run_random(PHASE_ITEMS);
        program_registers(8'd255, 8'd255, 8'd255);
        run_random(PHASE_ITEMS);
        program_registers(8'd255, 8'd0, 8'd255);
        run_random(PHASE_ITEMS);
        program_registers(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        run_random(PHASE_ITEMS);
        program_registers(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        run_random(PHASE_ITEMS);

        // drain, then watch for stray strobes
        idle_cycles(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("daily_heating_schedule_table: match");
        end else begin
            $display("daily_heating_schedule_table: mismatch");
        end
        $finish;
    end

endmodule
